>>> design/hpbl_pkg.sv
// Package for the haptic pulse budget limiter.
// Holds command, register and colour codes, reset values and the result word type.
// No dependencies.
package hpbl_pkg;

  localparam int QUADRANTS_DEF = 4;
  localparam int NFIELDS       = 4;   // intensity and duty ports on the top level

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_PULSE     = 2'd1,
    CMD_LINK_LOST = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MAX_PULSE  = 2'd0,
    REG_MAX_ON     = 2'd1,
    REG_MAX_DUTY   = 2'd2,
    REG_WINDOW     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    COL_CYAN      = 2'd0,
    COL_RED       = 2'd1,
    COL_GREEN     = 2'd2,
    COL_DARK_RED  = 2'd3
  } colour_t;

  localparam logic [15:0] MAX_PULSE_RST = 16'd200;
  localparam logic [15:0] MAX_ON_RST    = 16'd500;
  localparam logic [7:0]  MAX_DUTY_RST  = 8'd204;
  localparam logic [15:0] WINDOW_RST    = 16'd1000;

  typedef struct packed {
    logic [NFIELDS-1:0][7:0] duty;
    logic [NFIELDS-1:0]      refused;
    logic                    led_update;
    logic [1:0]              led_colour;
  } res_t;

endpackage

>>> design/haptic_pulse_budget_limiter.sv
// Haptic pulse budget limiter: top level with timer, budget guard and result buffer.
// Depends on hpbl_pkg.
//
//   channel | direction | handshake              | content
//   in_     | input     | in_valid / in_stall    | command, intensities, duration, flash
//   out_    | output    | out_valid / out_stall  | duties, refused mask, LED update/colour
//   cfg     | input     | APB psel/penable       | four limit registers, read back
//
// One word is accepted per cycle while in_stall is low; its result is registered in out_r.
// All state updates for a word happen at its accepting edge, in one pass of quadrant logic.
// A second result buffer holds a word while the output is stalled; in_stall rises only
// when that buffer is full.
// rst_n is synchronous; reset clears time, window, budgets, deadlines and duties and
// loads the default limits.
module haptic_pulse_budget_limiter #(
  parameter int QUADRANTS = hpbl_pkg::QUADRANTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [7:0]                  in_intensity_q0,
  input  logic [7:0]                  in_intensity_q1,
  input  logic [7:0]                  in_intensity_q2,
  input  logic [7:0]                  in_intensity_q3,
  input  logic [15:0]                 in_duration_ms,
  input  logic                        in_flash_request,
  input  logic                        in_perfect_hit,
  input  logic                        in_error_hit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_duty_q0,
  output logic [7:0]                  out_duty_q1,
  output logic [7:0]                  out_duty_q2,
  output logic [7:0]                  out_duty_q3,
  output logic [3:0]                  out_refused_mask,
  output logic                        out_led_update,
  output logic [1:0]                  out_led_colour,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hpbl_pkg::ADDR_W-1:0] paddr,
  input  logic [hpbl_pkg::DATA_W-1:0] pwdata,
  output logic [hpbl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import hpbl_pkg::*;

  // limit registers
  logic [15:0] max_pulse_r;
  logic [15:0] max_on_r;
  logic [7:0]  max_duty_r;
  logic [15:0] window_r;

  // block state
  logic [31:0] time_now_r, time_now_nxt;
  logic [31:0] window_start_r, window_start_nxt;
  logic [15:0] used_r     [QUADRANTS];
  logic [15:0] used_nxt   [QUADRANTS];
  logic [31:0] deadline_r [QUADRANTS];
  logic [31:0] deadline_nxt [QUADRANTS];
  logic [QUADRANTS-1:0] active_r, active_nxt;
  logic [7:0]  duty_r     [QUADRANTS];
  logic [7:0]  duty_nxt   [QUADRANTS];

  // result buffers
  res_t out_r, skid_r, res_nxt;
  logic out_valid_r, skid_valid_r;
  logic [NFIELDS-1:0][7:0] res_duty;
  logic [NFIELDS-1:0]      res_refused;

  logic [7:0]  in_int_f [NFIELDS];
  logic [7:0]  inten    [QUADRANTS];
  logic [QUADRANTS-1:0] refused;
  logic        accept, pop;
  cmd_t        cmd;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  logic [31:0] tick_time;
  logic [15:0] dur;
  logic [31:0] elapsed;
  logic [31:0] since;
  logic        any_pulse;
  logic        win_clear;
  logic [15:0] used_eff;
  logic [16:0] used_sum;

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;
  assign cmd      = cmd_t'(in_command);

  assign in_int_f[0] = in_intensity_q0;
  assign in_int_f[1] = in_intensity_q1;
  assign in_int_f[2] = in_intensity_q2;
  assign in_int_f[3] = in_intensity_q3;

  // quadrants beyond the intensity ports never fire
  for (genvar g = 0; g < QUADRANTS; g++) begin : g_inten
    if (g < NFIELDS) begin : g_port
      assign inten[g] = in_int_f[g];
    end else begin : g_zero
      assign inten[g] = 8'd0;
    end
  end

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MAX_PULSE: prdata = {16'd0, max_pulse_r};
      REG_MAX_ON:    prdata = {16'd0, max_on_r};
      REG_MAX_DUTY:  prdata = {24'd0, max_duty_r};
      REG_WINDOW:    prdata = {16'd0, window_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pulse_r <= MAX_PULSE_RST;
      max_on_r    <= MAX_ON_RST;
      max_duty_r  <= MAX_DUTY_RST;
      window_r    <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_PULSE: max_pulse_r <= pwdata[15:0];
        REG_MAX_ON:    max_on_r    <= pwdata[15:0];
        REG_MAX_DUTY:  max_duty_r  <= pwdata[7:0];
        REG_WINDOW:    window_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- per-word update ----------------
  assign tick_time = time_now_r + 32'd1;
  assign dur       = (in_duration_ms > max_pulse_r) ? max_pulse_r : in_duration_ms;
  assign elapsed   = time_now_r - window_start_r;

  always_comb begin
    any_pulse = 1'b0;
    for (int i = 0; i < QUADRANTS; i++) begin
      if (inten[i] != 8'd0) any_pulse = 1'b1;
    end
  end

  assign win_clear = any_pulse && (elapsed > {16'd0, window_r});

  always_comb begin
    time_now_nxt     = time_now_r;
    window_start_nxt = window_start_r;
    active_nxt       = active_r;
    refused          = '0;
    since            = '0;
    used_eff         = '0;
    used_sum         = '0;
    for (int i = 0; i < QUADRANTS; i++) begin
      used_nxt[i]     = used_r[i];
      deadline_nxt[i] = deadline_r[i];
      duty_nxt[i]     = duty_r[i];
    end

    unique case (cmd)
      CMD_TICK: begin
        time_now_nxt = tick_time;
        for (int i = 0; i < QUADRANTS; i++) begin
          since = tick_time - deadline_r[i];
          // deadline reached when the wrapped difference is non-negative
          if (active_r[i] && !since[31]) begin
            duty_nxt[i]   = 8'd0;
            active_nxt[i] = 1'b0;
          end
        end
      end
      CMD_PULSE: begin
        if (win_clear) window_start_nxt = time_now_r;
        for (int i = 0; i < QUADRANTS; i++) begin
          used_eff = win_clear ? 16'd0 : used_r[i];
          used_nxt[i] = used_eff;
          used_sum = {1'b0, used_eff} + {1'b0, dur};
          if (inten[i] != 8'd0) begin
            if (used_sum > {1'b0, max_on_r}) begin
              refused[i] = 1'b1;
            end else begin
              duty_nxt[i]     = (inten[i] < max_duty_r) ? inten[i] : max_duty_r;
              deadline_nxt[i] = time_now_r + {16'd0, dur};
              used_nxt[i]     = used_sum[15:0];
              active_nxt[i]   = 1'b1;
            end
          end
        end
      end
      CMD_LINK_LOST: begin
        for (int i = 0; i < QUADRANTS; i++) begin
          duty_nxt[i] = 8'd0;
        end
        active_nxt = '0;
      end
      default: ;
    endcase
  end

  // result word built from the updated duties
  for (genvar f = 0; f < NFIELDS; f++) begin : g_res
    if (f < QUADRANTS) begin : g_live
      assign res_duty[f]    = duty_nxt[f];
      assign res_refused[f] = refused[f];
    end else begin : g_absent
      assign res_duty[f]    = 8'd0;
      assign res_refused[f] = 1'b0;
    end
  end

  always_comb begin
    res_nxt.duty       = res_duty;
    res_nxt.refused    = res_refused;
    res_nxt.led_update = 1'b0;
    res_nxt.led_colour = COL_CYAN;
    unique case (cmd)
      CMD_PULSE: begin
        if (in_flash_request) begin
          res_nxt.led_update = 1'b1;
          priority if (in_perfect_hit) res_nxt.led_colour = COL_CYAN;
          else if (in_error_hit)       res_nxt.led_colour = COL_RED;
          else                         res_nxt.led_colour = COL_GREEN;
        end
      end
      CMD_LINK_LOST: begin
        res_nxt.led_update = 1'b1;
        res_nxt.led_colour = COL_DARK_RED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r     <= '0;
      window_start_r <= '0;
      active_r       <= '0;
      for (int i = 0; i < QUADRANTS; i++) begin
        used_r[i]     <= '0;
        deadline_r[i] <= '0;
        duty_r[i]     <= '0;
      end
    end else if (accept) begin
      time_now_r     <= time_now_nxt;
      window_start_r <= window_start_nxt;
      active_r       <= active_nxt;
      for (int i = 0; i < QUADRANTS; i++) begin
        used_r[i]     <= used_nxt[i];
        deadline_r[i] <= deadline_nxt[i];
        duty_r[i]     <= duty_nxt[i];
      end
    end
  end

  // ---------------- output register and skid buffer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // drain the held word first; input is stalled meanwhile
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty_q0      = out_r.duty[0];
  assign out_duty_q1      = out_r.duty[1];
  assign out_duty_q2      = out_r.duty[2];
  assign out_duty_q3      = out_r.duty[3];
  assign out_refused_mask = out_r.refused;
  assign out_led_update   = out_r.led_update;
  assign out_led_colour   = out_r.led_colour;

endmodule
